>>> rtl/qsbd_pkg.sv
`default_nettype none
package qsbd_pkg;

    // Field widths
    localparam int RxW     = 16;
    localparam int GainW   = 24;
    localparam int LlrW    = 16;
    localparam int CountW  = 4;
    localparam int ModeW   = 3;
    localparam int Lanes   = 8;

    // Internal datapath widths
    localparam int TermW   = 18;              // distance terms, Q2.13 with headroom
    localparam int NegW    = TermW + 1;       // negated term
    localparam int ProdW   = GainW + 1 + NegW; // gain times negated term
    localparam int ClampW  = 30;              // beyond this the result saturates anyway
    localparam int ScaleW  = 17;              // signed carrier for the output scale
    localparam int ScaledW = ClampW + ScaleW;
    localparam int RoundShift = 28;
    localparam int RoundedW = ScaledW - RoundShift;

    // Configuration register indexes
    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_GAIN = 1'b1;

    // Modulation codes
    localparam logic [ModeW-1:0] MODE_BPSK   = 3'd0;
    localparam logic [ModeW-1:0] MODE_QPSK   = 3'd1;
    localparam logic [ModeW-1:0] MODE_QAM16  = 3'd2;
    localparam logic [ModeW-1:0] MODE_QAM64  = 3'd3;
    localparam logic [ModeW-1:0] MODE_QAM256 = 3'd4;

    // Reset values of the registers
    localparam logic [ModeW-1:0] MODE_RESET = MODE_QPSK;
    localparam logic [GainW-1:0] GAIN_RESET = 24'd512;

    // Decision distances, Q2.13
    localparam logic signed [TermW-1:0] QAM16_D   = 18'sd5181;
    localparam logic signed [TermW-1:0] QAM64_D4  = 18'sd5056;
    localparam logic signed [TermW-1:0] QAM64_D2  = 18'sd2528;
    localparam logic signed [TermW-1:0] QAM256_D8 = 18'sd4230;
    localparam logic signed [TermW-1:0] QAM256_D4 = 18'sd2115;
    localparam logic signed [TermW-1:0] QAM256_D2 = 18'sd1058;

    // Output scales: 0.7071 in Q0.15 for QPSK, unity otherwise
    localparam logic [ScaleW-1:0] SCALE_QPSK  = 17'd23170;
    localparam logic [ScaleW-1:0] SCALE_UNITY = 17'd32768;

    // Valid bit counts
    localparam logic [CountW-1:0] COUNT_BPSK   = 4'd1;
    localparam logic [CountW-1:0] COUNT_QPSK   = 4'd2;
    localparam logic [CountW-1:0] COUNT_QAM16  = 4'd4;
    localparam logic [CountW-1:0] COUNT_QAM64  = 4'd6;
    localparam logic [CountW-1:0] COUNT_QAM256 = 4'd8;

    typedef struct packed {
        logic              valid;
        logic              qpsk;
        logic [CountW-1:0] bit_count;
    } ctrl_t;

endpackage
`default_nettype wire

>>> rtl/qsbd_term.sv
`default_nettype none
module qsbd_term
    import qsbd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire logic signed [RxW-1:0]   rx_i,
    input  wire logic signed [RxW-1:0]   rx_q,
    input  wire logic [ModeW-1:0]        mode,
    input  wire logic [GainW-1:0]        gain,
    output ctrl_t                        ctrl,
    output logic [GainW-1:0]             gain_out,
    output logic signed [NegW-1:0]       negterm [Lanes]
);

    function automatic logic signed [TermW-1:0] abs_term(input logic signed [TermW-1:0] t);
        abs_term = t[TermW-1] ? -t : t;
    endfunction

    // Capture stage
    logic                   valid_s1_reg;
    logic signed [RxW-1:0]  ri_s1_reg;
    logic signed [RxW-1:0]  rq_s1_reg;
    logic [ModeW-1:0]       mode_s1_reg;
    logic [GainW-1:0]       gain_s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_s1_reg <= 1'b0;
        end
        else
        begin
            valid_s1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ri_s1_reg   <= rx_i;
        rq_s1_reg   <= rx_q;
        mode_s1_reg <= mode;
        gain_s1_reg <= gain;
    end

    // Pick the distances for the mode
    logic signed [TermW-1:0] d1, d2, d3;

    always_comb
    begin
        d1 = '0;
        d2 = '0;
        d3 = '0;
        case (mode_s1_reg)
            MODE_QAM16:
            begin
                d1 = QAM16_D;
            end
            MODE_QAM64:
            begin
                d1 = QAM64_D4;
                d2 = QAM64_D2;
            end
            MODE_QAM256:
            begin
                d1 = QAM256_D8;
                d2 = QAM256_D4;
                d3 = QAM256_D2;
            end
            default:
            begin
                d1 = '0;
            end
        endcase
    end

    // Run the distance recurrence on both axes
    logic signed [TermW-1:0] ti [4];
    logic signed [TermW-1:0] tq [4];

    always_comb
    begin
        ti[0] = TermW'(ri_s1_reg);
        tq[0] = TermW'(rq_s1_reg);
        ti[1] = d1 - abs_term(ti[0]);
        tq[1] = d1 - abs_term(tq[0]);
        ti[2] = d2 - abs_term(ti[1]);
        tq[2] = d2 - abs_term(tq[1]);
        ti[3] = d3 - abs_term(ti[2]);
        tq[3] = d3 - abs_term(tq[2]);
    end

    // Place the terms on lanes, I bits first
    logic signed [TermW-1:0] lane_term [Lanes];
    ctrl_t                   ctrl_next;

    always_comb
    begin
        for (int k = 0; k < Lanes; k++)
        begin
            lane_term[k] = '0;
        end
        ctrl_next.valid = valid_s1_reg;
        ctrl_next.qpsk  = 1'b0;
        case (mode_s1_reg)
            MODE_BPSK:
            begin
                lane_term[0] = ti[0];
                ctrl_next.bit_count = COUNT_BPSK;
            end
            MODE_QAM16:
            begin
                lane_term[0] = ti[0];
                lane_term[1] = ti[1];
                lane_term[2] = tq[0];
                lane_term[3] = tq[1];
                ctrl_next.bit_count = COUNT_QAM16;
            end
            MODE_QAM64:
            begin
                lane_term[0] = ti[0];
                lane_term[1] = ti[1];
                lane_term[2] = ti[2];
                lane_term[3] = tq[0];
                lane_term[4] = tq[1];
                lane_term[5] = tq[2];
                ctrl_next.bit_count = COUNT_QAM64;
            end
            MODE_QAM256:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    lane_term[k]     = ti[k];
                    lane_term[k + 4] = tq[k];
                end
                ctrl_next.bit_count = COUNT_QAM256;
            end
            default:
            begin
                // QPSK and the spare codes
                lane_term[0] = ti[0];
                lane_term[1] = tq[0];
                ctrl_next.qpsk = 1'b1;
                ctrl_next.bit_count = COUNT_QPSK;
            end
        endcase
    end

    // Term stage register
    ctrl_t                   ctrl_reg;
    logic [GainW-1:0]        gain_s2_reg;
    logic signed [NegW-1:0]  negterm_reg [Lanes];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gain_s2_reg <= gain_s1_reg;
        for (int k = 0; k < Lanes; k++)
        begin
            negterm_reg[k] <= -NegW'(lane_term[k]);
        end
    end

    assign ctrl     = ctrl_reg;
    assign gain_out = gain_s2_reg;
    assign negterm  = negterm_reg;

endmodule
`default_nettype wire

>>> rtl/qsbd_lane.sv
`default_nettype none
module qsbd_lane
    import qsbd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic [GainW-1:0]        gain,
    input  wire logic signed [NegW-1:0]  negterm,
    input  wire logic                    qpsk,
    output logic signed [LlrW-1:0]       llr
);

    localparam logic signed [ClampW-1:0] ClampMax = {1'b0, {(ClampW-1){1'b1}}};
    localparam logic signed [ClampW-1:0] ClampMin = {1'b1, {(ClampW-1){1'b0}}};
    localparam logic signed [ScaledW-1:0] RoundHalf = ScaledW'(1) <<< (RoundShift - 1);
    localparam logic signed [RoundedW-1:0] LlrMax = RoundedW'(2**(LlrW-1) - 1);
    localparam logic signed [RoundedW-1:0] LlrMin = -RoundedW'(2**(LlrW-1));

    // Gain product
    logic signed [ProdW-1:0] prod_reg;
    logic                    qpsk_p1_reg;

    always_ff @(posedge clk)
    begin
        prod_reg    <= $signed({1'b0, gain}) * negterm;
        qpsk_p1_reg <= qpsk;
    end

    // Clamp the product; anything beyond the clamp saturates at the output
    logic signed [ClampW-1:0] clamp_next;
    logic signed [ClampW-1:0] clamp_reg;
    logic                     qpsk_p2_reg;
    logic                     fits;

    always_comb
    begin
        fits = (prod_reg[ProdW-1:ClampW-1] == '0) || (prod_reg[ProdW-1:ClampW-1] == '1);
        if (fits)
        begin
            clamp_next = prod_reg[ClampW-1:0];
        end
        else if (prod_reg[ProdW-1])
        begin
            clamp_next = ClampMin;
        end
        else
        begin
            clamp_next = ClampMax;
        end
    end

    always_ff @(posedge clk)
    begin
        clamp_reg   <= clamp_next;
        qpsk_p2_reg <= qpsk_p1_reg;
    end

    // Apply the output scale
    logic signed [ScaledW-1:0] scaled_reg;
    logic [ScaleW-1:0]         scale;

    assign scale = qpsk_p2_reg ? SCALE_QPSK : SCALE_UNITY;

    always_ff @(posedge clk)
    begin
        scaled_reg <= clamp_reg * $signed(scale);
    end

    // Round half up and saturate to Q8.8
    logic signed [ScaledW-1:0]  biased;
    logic signed [RoundedW-1:0] rounded;
    logic signed [LlrW-1:0]     llr_next;
    logic signed [LlrW-1:0]     llr_reg;

    always_comb
    begin
        biased  = scaled_reg + RoundHalf;
        rounded = biased[ScaledW-1:RoundShift];
        if (rounded > LlrMax)
        begin
            llr_next = LlrMax[LlrW-1:0];
        end
        else if (rounded < LlrMin)
        begin
            llr_next = LlrMin[LlrW-1:0];
        end
        else
        begin
            llr_next = rounded[LlrW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        llr_reg <= llr_next;
    end

    assign llr = llr_reg;

endmodule
`default_nettype wire

>>> rtl/qam_soft_bit_demapper_unit.sv
// Gray-QAM max-log soft-bit demapper.
// A started word passes the capture, term, product, clamp, scale and output registers.
// Throughput: one symbol per clock; busy stays low, every stage advances every cycle.
// The per-lane gain multiplier and the output scale multiplier each take a stage of their own.
// Reset (rst_n low, asynchronous) drops all words in flight and loads mode QPSK, gain 2.0.
`default_nettype none
module qam_soft_bit_demapper_unit
    import qsbd_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic                    cfg_addr,
    input  wire logic [GainW-1:0]        cfg_wdata,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic signed [RxW-1:0]   rx_inphase,
    input  wire logic signed [RxW-1:0]   rx_quadrature,
    output logic                         done,
    output logic signed [LlrW-1:0]       llr_0,
    output logic signed [LlrW-1:0]       llr_1,
    output logic signed [LlrW-1:0]       llr_2,
    output logic signed [LlrW-1:0]       llr_3,
    output logic signed [LlrW-1:0]       llr_4,
    output logic signed [LlrW-1:0]       llr_5,
    output logic signed [LlrW-1:0]       llr_6,
    output logic signed [LlrW-1:0]       llr_7,
    output logic [CountW-1:0]            bit_count
);

    localparam int LaneDepth = 4;

    // Configuration registers
    logic [ModeW-1:0] mode_reg;
    logic [GainW-1:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MODE: mode_reg <= cfg_wdata[ModeW-1:0];
                CFG_GAIN: gain_reg <= cfg_wdata;
                default:  mode_reg <= mode_reg;
            endcase
        end
    end

    // Never stall
    assign busy = 1'b0;

    // Term stages
    ctrl_t                  term_ctrl;
    logic [GainW-1:0]       term_gain;
    logic signed [NegW-1:0] term_neg [Lanes];

    qsbd_term u_term (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .rx_i     (rx_inphase),
        .rx_q     (rx_quadrature),
        .mode     (mode_reg),
        .gain     (gain_reg),
        .ctrl     (term_ctrl),
        .gain_out (term_gain),
        .negterm  (term_neg)
    );

    // Lane stages
    logic signed [LlrW-1:0] llr [Lanes];

    for (genvar k = 0; k < Lanes; k++)
    begin : g_lane
        qsbd_lane u_lane (
            .clk     (clk),
            .gain    (term_gain),
            .negterm (term_neg[k]),
            .qpsk    (term_ctrl.qpsk),
            .llr     (llr[k])
        );
    end

    // Carry valid and bit count alongside the lanes
    ctrl_t ctrl_pipe_reg [LaneDepth];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LaneDepth; s++)
            begin
                ctrl_pipe_reg[s] <= '0;
            end
        end
        else
        begin
            ctrl_pipe_reg[0] <= term_ctrl;
            for (int s = 1; s < LaneDepth; s++)
            begin
                ctrl_pipe_reg[s] <= ctrl_pipe_reg[s-1];
            end
        end
    end

    assign done      = ctrl_pipe_reg[LaneDepth-1].valid;
    assign bit_count = ctrl_pipe_reg[LaneDepth-1].bit_count;
    assign llr_0     = llr[0];
    assign llr_1     = llr[1];
    assign llr_2     = llr[2];
    assign llr_3     = llr[3];
    assign llr_4     = llr[4];
    assign llr_5     = llr[5];
    assign llr_6     = llr[6];
    assign llr_7     = llr[7];

endmodule
`default_nettype wire

>>> tb/qam_soft_bit_demapper_unit_test.sv
`timescale 1ns / 1ps
module qam_soft_bit_demapper_unit_test;
    import qsbd_pkg::*;

    localparam int TermShift  = 13;
    localparam int QpskShift  = 28;
    localparam int CycleLimit = 200000;
    localparam int Phases     = 18;
    localparam int PhaseWords = 50;

    // One demapped word: eight soft-bit lanes and the count of valid ones
    typedef struct packed {
        logic [Lanes-1:0][LlrW-1:0] lane;
        logic [CountW-1:0]          count;
    } llr_word_t;

    // Scoreboard: mirrors the mode and gain registers and predicts each word
    class llr_scoreboard;
        logic [ModeW-1:0] mode;
        logic [GainW-1:0] gain;
        llr_word_t        llr_expected_q[$];
        int               mismatches;
        int               words_checked;

        function new();
            mode          = MODE_RESET;
            gain          = GAIN_RESET;
            mismatches    = 0;
            words_checked = 0;
        endfunction

        function void write_reg(logic addr, logic [GainW-1:0] data);
            if (addr == CFG_MODE)
                mode = data[ModeW-1:0];
            else
                gain = data;
        endfunction

        function int pending();
            return llr_expected_q.size();
        endfunction

        // Scale one term by -gain (and 0.7071 for QPSK), round half up, saturate
        function logic [LlrW-1:0] scale_llr(longint term, bit qpsk);
            longint prod;
            longint rounded;
            prod = -(longint'(gain) * term);
            if (qpsk)
                rounded = (prod * longint'(SCALE_QPSK) + (64'sd1 <<< (QpskShift - 1)))
                          >>> QpskShift;
            else
                rounded = (prod + (64'sd1 <<< (TermShift - 1))) >>> TermShift;
            if (rounded > 32767)
                rounded = 32767;
            if (rounded < -32768)
                rounded = -32768;
            return rounded[LlrW-1:0];
        endfunction

        function llr_word_t demap(longint rx_i, longint rx_q);
            llr_word_t word;
            longint    spacing[3];
            longint    term;
            int        levels;
            int        slot;
            word   = '0;
            levels = 0;
            slot   = 0;
            case (mode)
                MODE_BPSK:
                begin
                    word.lane[0] = scale_llr(rx_i, 1'b0);
                    word.count   = COUNT_BPSK;
                    return word;
                end
                MODE_QAM16:
                begin
                    levels     = 1;
                    spacing[0] = QAM16_D;
                end
                MODE_QAM64:
                begin
                    levels     = 2;
                    spacing[0] = QAM64_D4;
                    spacing[1] = QAM64_D2;
                end
                MODE_QAM256:
                begin
                    levels     = 3;
                    spacing[0] = QAM256_D8;
                    spacing[1] = QAM256_D4;
                    spacing[2] = QAM256_D2;
                end
                default:
                begin
                    // QPSK and the undefined codes
                    word.lane[0] = scale_llr(rx_i, 1'b1);
                    word.lane[1] = scale_llr(rx_q, 1'b1);
                    word.count   = COUNT_QPSK;
                    return word;
                end
            endcase
            // I axis first, then Q: t0 = r, tk = dk - |t(k-1)|
            for (int axis = 0; axis < 2; axis++)
            begin
                term = (axis == 0) ? rx_i : rx_q;
                word.lane[slot] = scale_llr(term, 1'b0);
                slot++;
                for (int k = 0; k < levels; k++)
                begin
                    term = spacing[k] - ((term < 0) ? -term : term);
                    word.lane[slot] = scale_llr(term, 1'b0);
                    slot++;
                end
            end
            word.count = CountW'(slot);
            return word;
        endfunction

        function void note_symbol(logic signed [RxW-1:0] rx_i, logic signed [RxW-1:0] rx_q);
            llr_expected_q = {llr_expected_q, demap(longint'(rx_i), longint'(rx_q))};
        endfunction

        function void check_word(llr_word_t got);
            llr_word_t want;
            words_checked++;
            if (llr_expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected word lanes %h count %0d",
                             $realtime, got.lane, got.count);
                return;
            end
            want = llr_expected_q.pop_front();
            if (want != got)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: mismatch (mode %0d gain %0d)", $realtime, mode, gain);
                    for (int n = 0; n < Lanes; n++)
                        if (want.lane[n] != got.lane[n])
                            $display("    llr_%0d expected %0d got %0d", n,
                                     $signed(want.lane[n]), $signed(got.lane[n]));
                    if (want.count != got.count)
                        $display("    bit_count expected %0d got %0d", want.count, got.count);
                end
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic                     cfg_addr;
    logic [GainW-1:0]         cfg_wdata;
    logic                     start;
    logic                     busy;
    logic signed [RxW-1:0]    rx_inphase;
    logic signed [RxW-1:0]    rx_quadrature;
    logic                     done;
    logic signed [LlrW-1:0]   llr_0;
    logic signed [LlrW-1:0]   llr_1;
    logic signed [LlrW-1:0]   llr_2;
    logic signed [LlrW-1:0]   llr_3;
    logic signed [LlrW-1:0]   llr_4;
    logic signed [LlrW-1:0]   llr_5;
    logic signed [LlrW-1:0]   llr_6;
    logic signed [LlrW-1:0]   llr_7;
    logic [CountW-1:0]        bit_count;

    llr_scoreboard sb;
    int            symbols_sent;
    int            cycle_count;

    qam_soft_bit_demapper_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .start         (start),
        .busy          (busy),
        .rx_inphase    (rx_inphase),
        .rx_quadrature (rx_quadrature),
        .done          (done),
        .llr_0         (llr_0),
        .llr_1         (llr_1),
        .llr_2         (llr_2),
        .llr_3         (llr_3),
        .llr_4         (llr_4),
        .llr_5         (llr_5),
        .llr_6         (llr_6),
        .llr_7         (llr_7),
        .bit_count     (bit_count)
    );

    // 100 MHz clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // Monitor: check results first, then track register writes and accepted symbols
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (done !== 1'b0)
                sb.check_word({llr_7, llr_6, llr_5, llr_4, llr_3, llr_2, llr_1, llr_0,
                               bit_count});
            if (cfg_we)
                sb.write_reg(cfg_addr, cfg_wdata);
            if (start && !busy)
                sb.note_symbol(rx_inphase, rx_quadrature);
        end
    end

    // Present one symbol and hold it until the block takes it
    task automatic send_symbol(input logic signed [RxW-1:0] i_val,
                               input logic signed [RxW-1:0] q_val);
        start         <= 1'b1;
        rx_inphase    <= i_val;
        rx_quadrature <= q_val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        symbols_sent++;
    endtask

    task automatic idle(input int cycles);
        start <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    // Hold off until every predicted word has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Write mode then gain on back-to-back cycles
    task automatic set_config(input logic [GainW-1:0] mode_word,
                              input logic [GainW-1:0] gain_val);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_MODE;
        cfg_wdata <= mode_word;
        @(posedge clk);
        cfg_addr  <= CFG_GAIN;
        cfg_wdata <= gain_val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [RxW-1:0] pick_rx();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1:    return RxW'($urandom);
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       return -16'sd32768;
                    1:       return 16'sd32767;
                    2:       return 16'sd0;
                    default: return -16'sd1;
                endcase
            end
            default: return RxW'(int'($urandom_range(0, 18000)) - 9000);
        endcase
    endfunction

    function automatic logic [GainW-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return GainW'($urandom);
            3:       return GainW'(1);
            default: return GainW'($urandom_range(64, 8192));
        endcase
    endfunction

    initial
    begin
        logic [ModeW-1:0] phase_mode;
        bit               idling;
        sb            = new();
        symbols_sent  = 0;
        cycle_count   = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = CFG_MODE;
        cfg_wdata     = '0;
        start         = 1'b0;
        rx_inphase    = '0;
        rx_quadrature = '0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: QPSK at gain 2.0
        send_symbol(16'sd32767, -16'sd32768);
        send_symbol(16'sd0, 16'sd0);
        send_symbol(-16'sd1, 16'sd1);

        // BPSK at full gain: saturation both ways, quadrature ignored
        drain();
        set_config(GainW'(MODE_BPSK), '1);
        send_symbol(-16'sd32768, 16'sd12345);
        send_symbol(16'sd32767, -16'sd32768);
        send_symbol(16'sd1, -16'sd1);

        // BPSK at the smallest nonzero gain: rounding half up on exact halves
        drain();
        set_config(GainW'(MODE_BPSK), GainW'(1));
        send_symbol(16'sd4096, 16'sd0);
        send_symbol(-16'sd4096, 16'sd0);

        drain();
        set_config(GainW'(MODE_QAM16), GainW'(512));
        send_symbol(16'sd5181, -16'sd5181);
        send_symbol(16'sd32767, -16'sd32768);

        drain();
        set_config(GainW'(MODE_QAM64), GainW'(4096));
        send_symbol(16'sd5056, 16'sd2528);
        send_symbol(-16'sd2528, 16'sd0);

        drain();
        set_config(GainW'(MODE_QAM256), GainW'(256));
        send_symbol(16'sd4230, -16'sd2115);
        send_symbol(16'sd1058, -16'sd1058);
        send_symbol(-16'sd32768, 16'sd32767);

        // Undefined codes fall back to QPSK
        for (int code = MODE_QAM256 + 1; code < 8; code++)
        begin
            drain();
            set_config(GainW'(code), GainW'(700));
            send_symbol(-16'sd3000, 16'sd2500);
        end

        // Zero gain clears every lane
        drain();
        set_config(GainW'(MODE_QAM256), '0);
        send_symbol(16'sd32767, -16'sd32768);

        // Random phases, each under its own mode and gain
        for (int ph = 0; ph < Phases; ph++)
        begin
            phase_mode = (ph < 8) ? ModeW'(ph) : ModeW'($urandom_range(0, 7));
            idling     = (ph != 9);
            drain();
            set_config({(GainW - ModeW)'($urandom_range(0, (1 << (GainW - ModeW)) - 1)),
                        phase_mode},
                       pick_gain());
            for (int n = 0; n < PhaseWords; n++)
            begin
                if (idling && $urandom_range(0, 99) < 7)
                    idle(1);
                send_symbol(pick_rx(), pick_rx());
            end
        end

        // Let the pipeline empty, then keep watching for stray words
        drain();
        repeat (8)
            @(posedge clk);

        $display("sent %0d symbols over %0d random phases, checked %0d words", symbols_sent,
                 Phases, sb.words_checked);
        $display("covered all eight mode codes, gains from zero to full scale");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
        begin
            $display("%0d mismatches, %0d words outstanding", sb.mismatches, sb.pending());
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/qsbd_pkg.sv
rtl/qsbd_term.sv
rtl/qsbd_lane.sv
rtl/qam_soft_bit_demapper_unit.sv
tb/qam_soft_bit_demapper_unit_test.sv
